### design/pvsm_pkg.sv
`default_nettype none
package pvsm_pkg;

    localparam int VOICE_COUNT_DEF = 5;

    // Input opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_RATE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_STEP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_MIN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAN_SWEEP   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIX_LIMIT   = 3'd4;

    // Register reset values
    localparam logic [19:0] RST_SAMPLE_RATE = 20'd87934;
    localparam logic [15:0] RST_PAN_STEP    = 16'd1400;
    localparam logic [7:0]  RST_PAN_MIN     = 8'd72;
    localparam logic [7:0]  RST_PAN_SWEEP   = 8'd160;
    localparam logic [15:0] RST_MIX_LIMIT   = 16'd250;

    // Period divider widths: 20 bit sample rate over 16 bit freq
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 16;
    localparam logic [6:0] DUTY_MAX = 7'd100;

    // On count = product / 100 as (product * ceil(2^32 / 100)) >> 32,
    // exact for products below 2^27
    localparam int PCT_RECIP_W = 26;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 26'd42949673;
    localparam int PCT_SHIFT = 32;

    function automatic logic [7:0] pan_left_fixed(input logic [2:0] idx);
        logic [7:0] g;
        unique case (idx)
            3'd0:    g = 8'd96;
            3'd1:    g = 8'd240;
            3'd2:    g = 8'd220;
            3'd4:    g = 8'd190;
            default: g = 8'd128;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] pan_right_fixed(input logic [2:0] idx);
        logic [7:0] g;
        unique case (idx)
            3'd0:    g = 8'd240;
            3'd1:    g = 8'd96;
            3'd2:    g = 8'd120;
            3'd4:    g = 8'd190;
            default: g = 8'd128;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

### design/pvsm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module pvsm_div #(
    parameter int NUM_W = pvsm_pkg::DIV_NUM_W,
    parameter int DEN_W = pvsm_pkg::DIV_DEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_dividend,
    input  wire logic [DEN_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {r_rem, r_quo[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(rem_shift - {1'b0, r_den}) : rem_shift[DEN_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy)
        else $error("divider done while still busy");

    a_run_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy && (r_cnt == '0))
        else $error("divider did not start cleanly");

endmodule
`default_nettype wire

### design/pulse_voice_stereo_mixer.sv
`default_nettype none
// Pulse voice stereo mixer. Items arrive on the slave stream with the opcode in
// tuser: a sample tick returns one left/right level pair on the master stream,
// a set or off command updates one voice and returns nothing. One item is
// handled at a time. A tick runs the autopan step and two passes through the
// shared multiplier for the pan gains, then a phase step per voice plus two
// passes through the shared multiplier per sounding voice; it then waits while
// the previous level pair still sits unclaimed. A set command computes the
// period = sample_rate / freq in the 20-step bit-serial divider; the on count
// period*duty / 100 then takes one pass through the shared multiplier and one
// reciprocal multiply. Off commands, and sets with zero freq or duty, return
// to idle from their single state; ignored items leave the block idle. A
// finished level pair waits in an output register, so the next item is taken
// while the result is still unclaimed. Config writes are always accepted and
// must only be issued while the block is idle.
module pulse_voice_stereo_mixer #(
    parameter int VOICE_COUNT = pvsm_pkg::VOICE_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: voice[2:0], freq[18:3], duty[25:19], amplitude[41:26], zero pad
    input  wire logic [47:0]                     s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    // master stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: left_level[15:0], right_level[31:16]
    output logic [31:0]                          m_axis_tdata,
    // config write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pvsm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [pvsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VIDX_W = $clog2(VOICE_COUNT);
    localparam int MIX_W  = 16 + $clog2(VOICE_COUNT);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PAN   = 4'd1;
    localparam logic [3:0] S_GA    = 4'd2;
    localparam logic [3:0] S_GB    = 4'd3;
    localparam logic [3:0] S_PH    = 4'd4;
    localparam logic [3:0] S_ML    = 4'd5;
    localparam logic [3:0] S_MR    = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_SET   = 4'd8;
    localparam logic [3:0] S_DIVP  = 4'd9;
    localparam logic [3:0] S_MULD  = 4'd10;
    localparam logic [3:0] S_ONCNT = 4'd11;
    localparam logic [3:0] S_OFF   = 4'd12;

    // config registers
    logic [19:0] r_sample_rate;
    logic [15:0] r_pan_step;
    logic [7:0]  r_pan_min;
    logic [7:0]  r_pan_sweep;
    logic [15:0] r_mix_limit;

    // voice state
    logic [19:0] r_period [VOICE_COUNT];
    logic [19:0] r_on     [VOICE_COUNT];
    logic [19:0] r_phase  [VOICE_COUNT];
    logic [15:0] r_amp    [VOICE_COUNT];

    // autopan state
    logic [15:0] r_pan_tick;
    logic [8:0]  r_pan_pos;

    // sequencer and working registers
    logic [3:0]        r_state, n_state;
    logic [VIDX_W-1:0] r_vidx;
    logic [15:0]       r_freq;
    logic [6:0]        r_duty;
    logic [15:0]       r_amp_in;
    logic [19:0]       r_per;
    logic [26:0]       r_prod;     // period * duty
    logic [7:0]        r_gain_a;   // gain(255 - tri)
    logic [7:0]        r_gain_b;   // gain(tri)
    logic [MIX_W-1:0]  r_mix_l;
    logic [MIX_W-1:0]  r_mix_r;
    logic [15:0]       r_left;
    logic [15:0]       r_right;
    logic              r_out_valid;

    // shared multiplier
    logic [19:0] mul_a;
    logic [7:0]  mul_b;
    logic [27:0] mul_p;

    // on count reciprocal multiply
    logic [52:0] on_prod;

    // divider hookup
    logic                          div_start;
    logic [pvsm_pkg::DIV_NUM_W-1:0] div_num;
    logic [pvsm_pkg::DIV_DEN_W-1:0] div_den;
    logic                          div_busy;
    logic                          div_done;
    logic [pvsm_pkg::DIV_NUM_W-1:0] div_quo;

    logic        in_xfer;
    logic        voice_ok;
    logic [7:0]  tri_pos;
    logic [8:0]  gain_sum;
    logic [7:0]  gain_sat;
    logic [15:0] tick_inc;
    logic [19:0] ph_inc;
    logic [19:0] ph_new;
    logic [7:0]  pan_l;
    logic [7:0]  pan_r;
    logic [2:0]  vidx3;
    logic        last_voice;
    logic        out_free;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign voice_ok  = {1'b0, s_axis_tdata[2:0]} < 4'(VOICE_COUNT);
    assign out_free  = !r_out_valid || m_axis_tready;
    assign last_voice = r_vidx == VIDX_W'(VOICE_COUNT - 1);
    assign vidx3     = 3'(r_vidx);

    // triangle: 511 - pos for the upper half equals ~pos[7:0]
    assign tri_pos  = r_pan_pos[8] ? ~r_pan_pos[7:0] : r_pan_pos[7:0];
    assign tick_inc = r_pan_tick + 16'd1;

    assign ph_inc = r_phase[r_vidx] + 20'd1;
    assign ph_new = (ph_inc >= r_period[r_vidx]) ? 20'd0 : ph_inc;

    // voice 0 pans with the sweep, voice 2 mirrored, the rest fixed
    always_comb begin
        pan_l = pvsm_pkg::pan_left_fixed(vidx3);
        pan_r = pvsm_pkg::pan_right_fixed(vidx3);
        if (vidx3 == 3'd0) begin
            pan_l = r_gain_a;
            pan_r = r_gain_b;
        end else if (vidx3 == 3'd2) begin
            pan_l = r_gain_b;
            pan_r = r_gain_a;
        end
    end

    always_comb begin
        mul_a = 20'(r_amp[r_vidx]);
        mul_b = pan_l;
        unique case (r_state)
            S_GA:    begin mul_a = {12'd0, ~tri_pos}; mul_b = r_pan_sweep; end
            S_GB:    begin mul_a = {12'd0, tri_pos};  mul_b = r_pan_sweep; end
            S_MR:    begin mul_b = pan_r; end
            S_MULD:  begin mul_a = r_per; mul_b = 8'(r_duty); end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign gain_sum = {1'b0, r_pan_min} + {1'b0, mul_p[15:8]};
    assign gain_sat = gain_sum[8] ? 8'hFF : gain_sum[7:0];

    // on count: period*duty / 100 by reciprocal
    assign on_prod = {26'd0, r_prod} * {27'd0, pvsm_pkg::PCT_RECIP};

    // divider: period = sample_rate / freq
    assign div_start = r_state == S_SET && r_freq != '0 && r_duty != '0;
    assign div_num   = r_sample_rate;
    assign div_den   = r_freq;

    pvsm_div #(
        .NUM_W (pvsm_pkg::DIV_NUM_W),
        .DEN_W (pvsm_pkg::DIV_DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    priority if (s_axis_tuser == pvsm_pkg::OP_TICK) n_state = S_PAN;
                    else if (s_axis_tuser == pvsm_pkg::OP_SET && voice_ok) n_state = S_SET;
                    else if (s_axis_tuser == pvsm_pkg::OP_OFF && voice_ok) n_state = S_OFF;
                    else n_state = S_IDLE;
                end
            end
            S_PAN:  n_state = S_GA;
            S_GA:   n_state = S_GB;
            S_GB:   n_state = S_PH;
            S_PH: begin
                if (r_period[r_vidx] != '0 && ph_new < r_on[r_vidx]) n_state = S_ML;
                else if (last_voice) n_state = S_OUT;
            end
            S_ML:   n_state = S_MR;
            S_MR:   n_state = last_voice ? S_OUT : S_PH;
            S_OUT:  if (out_free) n_state = S_IDLE;
            S_SET:  n_state = (r_freq != '0 && r_duty != '0) ? S_DIVP : S_IDLE;
            S_DIVP: if (div_done) n_state = S_MULD;
            S_MULD: n_state = S_ONCNT;
            S_ONCNT: n_state = S_IDLE;
            S_OFF:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_pan_tick    <= '0;
            r_pan_pos     <= '0;
            r_sample_rate <= pvsm_pkg::RST_SAMPLE_RATE;
            r_pan_step    <= pvsm_pkg::RST_PAN_STEP;
            r_pan_min     <= pvsm_pkg::RST_PAN_MIN;
            r_pan_sweep   <= pvsm_pkg::RST_PAN_SWEEP;
            r_mix_limit   <= pvsm_pkg::RST_MIX_LIMIT;
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_period[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    pvsm_pkg::CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                    pvsm_pkg::CFG_PAN_STEP:    r_pan_step    <= i_cfg_data[15:0];
                    pvsm_pkg::CFG_PAN_MIN:     r_pan_min     <= i_cfg_data[7:0];
                    pvsm_pkg::CFG_PAN_SWEEP:   r_pan_sweep   <= i_cfg_data[7:0];
                    pvsm_pkg::CFG_MIX_LIMIT:   r_mix_limit   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // autopan advance, once per tick
            if (r_state == S_PAN) begin
                if (tick_inc >= r_pan_step) begin
                    r_pan_tick <= '0;
                    r_pan_pos  <= r_pan_pos + 9'd1;
                end else begin
                    r_pan_tick <= tick_inc;
                end
            end

            // a set or off clears the period; a set with nonzero freq and duty rewrites it when it completes
            if (r_state == S_SET || r_state == S_OFF) begin
                r_period[r_vidx] <= '0;
            end else if (r_state == S_ONCNT) begin
                r_period[r_vidx] <= r_per;
            end

            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer) begin
            r_vidx   <= s_axis_tdata[VIDX_W-1:0];
            r_freq   <= s_axis_tdata[18:3];
            r_duty   <= (s_axis_tdata[25:19] > pvsm_pkg::DUTY_MAX) ? pvsm_pkg::DUTY_MAX
                                                                : s_axis_tdata[25:19];
            r_amp_in <= s_axis_tdata[41:26];
        end

        unique case (r_state)
            S_PAN: begin
                r_vidx  <= '0;
                r_mix_l <= '0;
                r_mix_r <= '0;
            end
            S_GA: r_gain_a <= gain_sat;
            S_GB: r_gain_b <= gain_sat;
            S_PH: begin
                if (r_period[r_vidx] != '0) r_phase[r_vidx] <= ph_new;
                if (!(r_period[r_vidx] != '0 && ph_new < r_on[r_vidx]) && !last_voice)
                    r_vidx <= r_vidx + 1'b1;
            end
            S_ML: r_mix_l <= r_mix_l + MIX_W'(mul_p[23:8]);
            S_MR: begin
                r_mix_r <= r_mix_r + MIX_W'(mul_p[23:8]);
                if (!last_voice) r_vidx <= r_vidx + 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    r_left  <= (r_mix_l > MIX_W'(r_mix_limit)) ? r_mix_limit : r_mix_l[15:0];
                    r_right <= (r_mix_r > MIX_W'(r_mix_limit)) ? r_mix_limit : r_mix_r[15:0];
                end
            end
            S_DIVP: begin
                // a quotient of zero becomes one
                if (div_done) r_per <= (div_quo == '0) ? 20'd1 : div_quo;
            end
            S_MULD: r_prod <= mul_p[26:0];
            S_ONCNT: begin
                r_phase[r_vidx] <= '0;
                r_on[r_vidx]    <= on_prod[pvsm_pkg::PCT_SHIFT +: 20];
                r_amp[r_vidx]   <= r_amp_in;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_right, r_left};
    assign o_cfg_ready   = 1'b1;

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVP))
        else $error("divider finished outside a set command");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_level_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata[15:0] <= r_mix_limit &&
                                  m_axis_tdata[31:16] <= r_mix_limit))
        else $error("output level above mix limit");

endmodule
`default_nettype wire

### bench/tb_pulse_voice_stereo_mixer.sv
`timescale 1ns / 100ps

module tb_pulse_voice_stereo_mixer;

    localparam int VC = pvsm_pkg::VOICE_COUNT_DEF;

    // opcode 3 has no meaning; the block must swallow it without a result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // duty is clamped to full on; on count = period * duty / 100
    localparam logic [6:0] DUTY_FULL = 7'd100;
    localparam int unsigned PCT_SCALE = 100;

    // cycles allowed after the last level pair for a set command to finish
    localparam int SETTLE_CYCLES = 200;

    // long receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER_ITEMS = 80;

    // fixed pan gains of the voices that are not autopanned
    localparam logic [7:0] FIXED_PAN_L [0:7] = '{8'd96, 8'd240, 8'd220, 8'd128,
                                                  8'd190, 8'd128, 8'd128, 8'd128};
    localparam logic [7:0] FIXED_PAN_R [0:7] = '{8'd240, 8'd96, 8'd120, 8'd128,
                                                  8'd190, 8'd128, 8'd128, 8'd128};

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  voice;
        logic [15:0] freq;
        logic [6:0]  duty;
        logic [15:0] amp;
    } t_voice_item;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
    } t_level_pair;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_COMB
    } t_rx_mode;

    // ---------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ---------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: voice[2:0], freq[18:3], duty[25:19], amplitude[41:26], zero pad
    logic [47:0]           s_axis_tdata = '0;
    // tuser: opcode[1:0]
    logic [1:0]            s_axis_tuser = pvsm_pkg::OP_TICK;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: left_level[15:0], right_level[31:16]
    logic [31:0]           m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [pvsm_pkg::CFG_ADDR_W-1:0] i_cfg_addr = pvsm_pkg::CFG_SAMPLE_RATE;
    logic [pvsm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pulse_voice_stereo_mixer #(
        .VOICE_COUNT(VC)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Mixer shadow: configuration copy and per-voice state
    // ---------------------------------------------------------------
    logic [19:0] cfg_rate;
    logic [15:0] cfg_step;
    logic [7:0]  cfg_min;
    logic [7:0]  cfg_sweep;
    logic [15:0] cfg_limit;

    logic [19:0] sh_period [VC];   // 0 = voice silent
    logic [19:0] sh_on     [VC];
    logic [19:0] sh_phase  [VC];
    logic [15:0] sh_amp    [VC];
    logic [15:0] sh_pan_ticks;
    logic [8:0]  sh_pan_pos;

    t_voice_item  voice_items[$];      // items waiting for the sender
    t_level_pair  expected_levels[$];  // level pairs still owed by the block

    int sent_count = 0;      // items put on the slave bus
    int acc_count = 0;       // slave transfers seen
    int cfg_xfer_count = 0;  // config transfers seen
    int level_count = 0;     // master transfers checked
    int mismatch_count = 0;
    int n_ticks = 0;
    int n_sets = 0;
    int n_offs = 0;
    int n_ignored = 0;
    int n_settings = 1;

    logic rx_hold = 1'b0;

    // autopan gain: base plus swept part, saturating at full scale
    function automatic logic [7:0] sweep_gain(input logic [7:0] pos);
        logic [31:0] g;
        g = 32'(cfg_min) + ((32'(pos) * 32'(cfg_sweep)) >> 8);
        return (g > 32'd255) ? 8'd255 : g[7:0];
    endfunction

    // Apply one accepted item to the shadow; a tick queues its level pair.
    task automatic predict_mix(input t_voice_item it);
        int          v;
        logic [31:0] per;
        logic [31:0] ph;
        logic [31:0] sum_l;
        logic [31:0] sum_r;
        logic [7:0]  gl;
        logic [7:0]  gr;
        logic [7:0]  sweep_pos;
        logic [7:0]  q;
        logic [6:0]  duty;
        t_level_pair lv;
        v = int'(it.voice);
        case (it.opcode)
            pvsm_pkg::OP_SET: begin
                if (v >= VC) begin
                    n_ignored++;
                end else begin
                    n_sets++;
                    sh_period[v] = '0;
                    // zero freq or duty silences the voice, rest is kept
                    if (it.freq != '0 && it.duty != '0) begin
                        duty = (it.duty > DUTY_FULL) ? DUTY_FULL : it.duty;
                        per = 32'(cfg_rate) / 32'(it.freq);
                        if (per == 0)
                            per = 1;
                        sh_phase[v] = '0;
                        sh_on[v] = 20'((per * 32'(duty)) / PCT_SCALE);
                        sh_amp[v] = it.amp;
                        sh_period[v] = per[19:0];
                    end
                end
            end
            pvsm_pkg::OP_OFF: begin
                if (v >= VC) begin
                    n_ignored++;
                end else begin
                    n_offs++;
                    sh_period[v] = '0;
                end
            end
            pvsm_pkg::OP_TICK: begin
                n_ticks++;
                sh_pan_ticks = sh_pan_ticks + 16'd1;
                if (sh_pan_ticks >= cfg_step) begin
                    sh_pan_ticks = '0;
                    sh_pan_pos = sh_pan_pos + 9'd1;  // wraps at 512
                end
                // triangle: up over the first half, back down over the second
                sweep_pos = sh_pan_pos[8] ? (8'd255 - sh_pan_pos[7:0]) : sh_pan_pos[7:0];
                sum_l = '0;
                sum_r = '0;
                for (int i = 0; i < VC; i++) begin
                    if (sh_period[i] == '0)
                        continue;
                    ph = 32'(sh_phase[i]) + 1;
                    if (ph >= 32'(sh_period[i]))
                        ph = 0;
                    sh_phase[i] = ph[19:0];
                    if (sh_phase[i] >= sh_on[i])
                        continue;
                    gl = FIXED_PAN_L[i];
                    gr = FIXED_PAN_R[i];
                    if (i == 0 || i == 2) begin
                        // voice 2 pans against voice 0
                        q = (i == 0) ? sweep_pos : (8'd255 - sweep_pos);
                        gl = sweep_gain(8'd255 - q);
                        gr = sweep_gain(q);
                    end
                    sum_l += (32'(sh_amp[i]) * 32'(gl)) >> 8;
                    sum_r += (32'(sh_amp[i]) * 32'(gr)) >> 8;
                end
                if (sum_l > 32'(cfg_limit))
                    sum_l = 32'(cfg_limit);
                if (sum_r > 32'(cfg_limit))
                    sum_r = 32'(cfg_limit);
                lv.left = sum_l[15:0];
                lv.right = sum_r[15:0];
                expected_levels.push_back(lv);
            end
            default: n_ignored++;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Monitor: config transfers, slave transfers and level pairs
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_voice_item it;
        t_level_pair want;
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                pvsm_pkg::CFG_SAMPLE_RATE: cfg_rate = i_cfg_data;
                pvsm_pkg::CFG_PAN_STEP:    cfg_step = i_cfg_data[15:0];
                pvsm_pkg::CFG_PAN_MIN:     cfg_min = i_cfg_data[7:0];
                pvsm_pkg::CFG_PAN_SWEEP:   cfg_sweep = i_cfg_data[7:0];
                pvsm_pkg::CFG_MIX_LIMIT:   cfg_limit = i_cfg_data[15:0];
                default: ;
            endcase
            cfg_xfer_count++;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            it.opcode = s_axis_tuser;
            it.voice = s_axis_tdata[2:0];
            it.freq = s_axis_tdata[18:3];
            it.duty = s_axis_tdata[25:19];
            it.amp = s_axis_tdata[41:26];
            predict_mix(it);
            acc_count++;
        end
        // the level pair of an item never leaves on the edge that took it in
        if (m_axis_tvalid && m_axis_tready) begin
            level_count++;
            if (expected_levels.size() == 0) begin
                $error("level pair with nothing owed: left %0d right %0d",
                       m_axis_tdata[15:0], m_axis_tdata[31:16]);
                mismatch_count++;
            end else begin
                want = expected_levels.pop_front();
                if (m_axis_tdata[15:0] !== want.left) begin
                    $error("left_level: expected %0d, got %0d", want.left,
                           m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[31:16] !== want.right) begin
                    $error("right_level: expected %0d, got %0d", want.right,
                           m_axis_tdata[31:16]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps; held data stays put
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge i_clk) begin : sender
        logic        next_valid;
        t_voice_item nxt;
        next_valid = s_axis_tvalid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && acc_count == sent_count) begin
                next_valid = 1'b0;
                burst_left--;
                if (burst_left <= 0) begin
                    // now and then a long burst with no idling at all
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(30, 60);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(1, 8);
                    end
                end
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (voice_items.size() != 0) begin
                    nxt = voice_items.pop_front();
                    next_valid = 1'b1;
                    s_axis_tdata <= {6'd0, nxt.amp, nxt.duty, nxt.freq, nxt.voice};
                    s_axis_tuser <= nxt.opcode;
                    sent_count++;
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // ---------------------------------------------------------------
    // Receiver: ready pattern switches between modes every so often
    // ---------------------------------------------------------------
    t_rx_mode rx_mode = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_cycle = 0;

    always @(negedge i_clk) begin : receiver
        logic next_ready;
        if (rx_mode_left <= 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_cycle++;
        case (rx_mode)
            RX_FREE: next_ready = 1'b1;
            RX_COIN: next_ready = 1'($urandom_range(0, 1));
            RX_SLOW: next_ready = ($urandom_range(0, 4) == 0);
            default: next_ready = (rx_cycle % 5) != 0;
        endcase
        if (rx_hold)
            next_ready = 1'b0;
        m_axis_tready <= next_ready;
    end

    // long hold-off once traffic is flowing; the sender keeps offering
    initial begin : hold_off
        while (acc_count < HOLD_AFTER_ITEMS)
            @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_item(input logic [1:0] op, input logic [2:0] v,
                             input logic [15:0] f, input logic [6:0] d,
                             input logic [15:0] a);
        t_voice_item it;
        it.opcode = op;
        it.voice = v;
        it.freq = f;
        it.duty = d;
        it.amp = a;
        voice_items.push_back(it);
    endtask

    // Mostly ticks and well-formed set/off commands, some noise.
    function automatic t_voice_item random_voice_item();
        t_voice_item it;
        int          r;
        int unsigned f;
        r = $urandom_range(0, 99);
        it.voice = 3'($urandom_range(0, VC - 1));
        it.freq = 16'($urandom_range(0, 65535));
        it.duty = 7'($urandom_range(0, 127));
        it.amp = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 2000))
                                             : 16'($urandom_range(0, 65535));
        if (r < 60) begin
            it.opcode = pvsm_pkg::OP_TICK;
            it.voice = 3'($urandom_range(0, 7));
        end else if (r < 82) begin
            it.opcode = pvsm_pkg::OP_SET;
            case ($urandom_range(0, 9))
                0: it.freq = '0;
                1, 2: it.freq = 16'($urandom_range(0, 65535));
                default: begin
                    // aim for short periods so voices toggle often
                    f = cfg_rate / $urandom_range(2, 40);
                    if (f == 0)
                        f = 1;
                    if (f > 65535)
                        f = 65535;
                    it.freq = f[15:0];
                end
            endcase
            if ($urandom_range(0, 9) != 0)
                it.duty = 7'($urandom_range(1, 100));
        end else if (r < 90) begin
            it.opcode = pvsm_pkg::OP_OFF;
        end else begin
            case ($urandom_range(0, 2))
                0: it.opcode = OP_UNUSED;
                1: it.opcode = pvsm_pkg::OP_SET;
                default: it.opcode = pvsm_pkg::OP_OFF;
            endcase
            if (it.opcode != OP_UNUSED)
                it.voice = 3'($urandom_range(VC, 7));
        end
        return it;
    endfunction

    task automatic write_reg(input logic [pvsm_pkg::CFG_ADDR_W-1:0] a,
                             input logic [pvsm_pkg::CFG_DATA_W-1:0] d);
        int start;
        @(negedge i_clk);
        start = cfg_xfer_count;
        i_cfg_valid = 1'b1;
        i_cfg_addr = a;
        i_cfg_data = d;
        do @(negedge i_clk); while (cfg_xfer_count == start);
        i_cfg_valid = 1'b0;
    endtask

    // everything sent, taken and answered; then let a set command finish
    task automatic wait_idle();
        while (voice_items.size() != 0 || sent_count != acc_count ||
               expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_setting(input logic [19:0] rate, input logic [15:0] step,
                               input logic [7:0] pmin, input logic [7:0] psweep,
                               input logic [15:0] lim, input int n);
        write_reg(pvsm_pkg::CFG_SAMPLE_RATE, rate);
        write_reg(pvsm_pkg::CFG_PAN_STEP, 20'(step));
        write_reg(pvsm_pkg::CFG_PAN_MIN, 20'(pmin));
        write_reg(pvsm_pkg::CFG_PAN_SWEEP, 20'(psweep));
        write_reg(pvsm_pkg::CFG_MIX_LIMIT, 20'(lim));
        n_settings++;
        repeat (n) voice_items.push_back(random_voice_item());
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main
        cfg_rate = pvsm_pkg::RST_SAMPLE_RATE;
        cfg_step = pvsm_pkg::RST_PAN_STEP;
        cfg_min = pvsm_pkg::RST_PAN_MIN;
        cfg_sweep = pvsm_pkg::RST_PAN_SWEEP;
        cfg_limit = pvsm_pkg::RST_MIX_LIMIT;
        for (int i = 0; i < VC; i++) begin
            sh_period[i] = '0;
            sh_on[i] = '0;
            sh_phase[i] = '0;
            sh_amp[i] = '0;
        end
        sh_pan_ticks = '0;
        sh_pan_pos = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed pass at reset settings
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);      // all silent
        push_item(pvsm_pkg::OP_SET,  3'd0, 16'd1000, 7'd50,  16'hFFFF);
        push_item(pvsm_pkg::OP_SET,  3'd1, 16'hFFFF, 7'd100, 16'hFFFF);   // shortest period, 1
        push_item(pvsm_pkg::OP_SET,  3'd2, 16'd1,    7'd127, 16'd1000);   // duty clamps
        push_item(pvsm_pkg::OP_SET,  3'd3, 16'd0,    7'd50,  16'd500);    // zero freq: off
        push_item(pvsm_pkg::OP_SET,  3'd4, 16'd5000, 7'd0,   16'd700);    // zero duty: off
        push_item(pvsm_pkg::OP_SET,  3'd5, 16'd100,  7'd50,  16'd100);    // voice out of range
        push_item(pvsm_pkg::OP_OFF,  3'd7, 16'hFFFF, 7'h7F,  16'hFFFF);   // voice out of range
        push_item(OP_UNUSED,         3'd7, 16'hFFFF, 7'h7F,  16'hFFFF);   // unused opcode
        push_item(pvsm_pkg::OP_TICK, 3'd7, 16'hFFFF, 7'h7F,  16'hFFFF);
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_SET,  3'd3, 16'd2000, 7'd1,   16'd40000);  // on count of zero
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_OFF,  3'd1, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_SET,  3'd4, 16'd3000, 7'd75,  16'hFFFF);
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_OFF,  3'd0, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_OFF,  3'd2, 16'd0,    7'd0,   16'd0);
        push_item(pvsm_pkg::OP_TICK, 3'd0, 16'd0,    7'd0,   16'd0);
        wait_idle();

        // fast autopan, full sweep, ceiling at full scale
        run_setting(20'd48000, 16'd1, 8'd0, 8'd255, 16'hFFFF, 170);
        // top sample rate, gain overflow, moderate ceiling
        run_setting(20'hFFFFF, 16'd3, 8'd255, 8'd255, 16'd1000, 100);
        // lowest rate, slowest autopan, everything clipped to zero
        run_setting(20'd1, 16'hFFFF, 8'd40, 8'd0, 16'd0, 60);
        // autopan step of zero, random gains and ceiling
        run_setting(20'($urandom_range(1000, 200000)), 16'd0,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    16'($urandom_range(100, 65535)), 110);
        // back to the power-up values
        run_setting(pvsm_pkg::RST_SAMPLE_RATE, pvsm_pkg::RST_PAN_STEP,
                    pvsm_pkg::RST_PAN_MIN, pvsm_pkg::RST_PAN_SWEEP,
                    pvsm_pkg::RST_MIX_LIMIT, 110);

        if (expected_levels.size() != 0) begin
            $error("%0d level pairs never arrived", expected_levels.size());
            mismatch_count++;
        end

        $display("covered %0d ticks, %0d sets, %0d offs, %0d ignored items",
                 n_ticks, n_sets, n_offs, n_ignored);
        $display("checked %0d level pairs over %0d register settings, %0d errors",
                 level_count, n_settings, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
design/pvsm_pkg.sv
design/pvsm_div.sv
design/pulse_voice_stereo_mixer.sv
bench/tb_pulse_voice_stereo_mixer.sv
